FILE: rtl/ttcn_pkg.sv
// ttcn_pkg: shared constants, codes, types and helper functions of the
// truth table compose/normalize block. No dependencies.
package ttcn_pkg;

	localparam int MAX_VARS    = 6;
	localparam int VAR_ID_BITS = 16;
	localparam int NLAB        = 3;
	localparam int SLOT_W      = 3;
	localparam int TBL_W       = 64;
	localparam int LANES       = 4;
	localparam int LANE_W      = 2;
	localparam int CHUNK_W     = 4;
	localparam int CHUNKS      = TBL_W / LANES;
	localparam int IN_W        = 80;
	localparam int OUT_W       = 96;
	localparam int CFG_W       = 3;
	localparam logic [CFG_W-1:0] TS_RESET = 3'd6;

	typedef logic [VAR_ID_BITS-1:0] vid_t;

	typedef enum logic [1:0] {
		CMD_IMPORT    = 2'd0,
		CMD_COMPOSE   = 2'd1,
		CMD_NORMALIZE = 2'd2,
		CMD_NOP       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_OVERFLOW   = 2'd1,
		ST_BAD_LABELS = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SRC_JJ,
		SRC_ZERO,
		SRC_G
	} src_mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_PLAN,
		S_EVAL,
		S_COMMIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic               load;
		logic               prep;
		logic               plan;
		logic               eval;
		logic               commit;
		logic               beat_adv;
		logic [CHUNK_W-1:0] chunk;
	} ctl_cmd_t;

	typedef struct packed {
		logic last_beat;
	} dp_stat_t;

	function automatic logic [TBL_W-1:0] used_mask(input logic [SLOT_W-1:0] n);
		logic [TBL_W-1:0] m;
		logic [7:0] lim;
		lim = 8'd1 << n;
		for (int j = 0; j < TBL_W; j++) begin
			m[j] = (8'(j) < lim);
		end
		return m;
	endfunction

	function automatic logic gval(input logic [7:0] gt, input logic [1:0] k,
			input logic [NLAB-1:0] gi);
		logic [2:0] idx;
		idx[2] = (k > 2'd0) && gi[0];
		idx[1] = (k > 2'd1) && gi[1];
		idx[0] = (k > 2'd2) && gi[2];
		return gt[idx];
	endfunction

endpackage

FILE: rtl/truth_table_compose_normalize_core.sv
// truth_table_compose_normalize_core: top level of the truth table block.
// Depends on ttcn_pkg, ttcn_ctrl and ttcn_dp.
//
// Holds one Boolean function of up to six variables (sorted id list and a
// 64-bit truth table) and runs import, compose, normalize or nop on each input
// beat, then returns one output beat per variable (one beat for an empty
// list), tlast on the final one. Beats are handled one at a time: the next
// input beat is taken only after the final output beat. The table rebuild
// produces four table bits per cycle. The user must write table_size through
// cfg_* only while idle; the block itself does not enforce this.
module truth_table_compose_normalize_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// cmd[1:0] g_table[9:2] g_var_count[11:10] g_var0[27:12] g_var1[43:28]
	// g_var2[59:44] target_var[75:60], zero above
	input  logic [ttcn_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// status[1:0] num_vars[4:2] table_res[68:5] var_slot[71:69]
	// var_id[87:72] var_valid[88], zero above
	output logic [ttcn_pkg::OUT_W-1:0]   m_tdata,
	output logic                         m_tlast,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ttcn_pkg::CFG_W-1:0]   cfg_data
);
	import ttcn_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;
	assign m_tlast   = stat.last_beat;

	ttcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	ttcn_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_valid),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata)
	);

endmodule

FILE: rtl/ttcn_ctrl.sv
// ttcn_ctrl: sequencing state machine of the truth table block.
// Depends on ttcn_pkg; drives the datapath ttcn_dp through ctl_cmd_t.
module ttcn_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  ttcn_pkg::dp_stat_t  stat,
	output ttcn_pkg::ctl_cmd_t  ctl
);
	import ttcn_pkg::*;

	state_t state_q, state_d;
	logic [CHUNK_W-1:0] chunk_q, chunk_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chunk_q <= '0;
		end else begin
			state_q <= state_d;
			chunk_q <= chunk_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		chunk_d      = chunk_q;
		s_tready     = 1'b0;
		m_tvalid     = 1'b0;
		ctl          = '0;
		ctl.chunk    = chunk_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				ctl.prep = 1'b1;
				state_d  = S_PLAN;
			end
			S_PLAN: begin
				ctl.plan = 1'b1;
				chunk_d  = '0;
				state_d  = S_EVAL;
			end
			S_EVAL: begin
				ctl.eval = 1'b1;
				chunk_d  = chunk_q + 1'b1;
				if (chunk_q == CHUNK_W'(CHUNKS - 1)) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (stat.last_beat) begin
						state_d = S_IDLE;
					end else begin
						ctl.beat_adv = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/ttcn_dp.sv
// ttcn_dp: datapath of the truth table block: function state, list merge,
// redundancy check, four-lane table rebuild and result beats.
// Depends on ttcn_pkg; controlled by ttcn_ctrl.
module ttcn_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ttcn_pkg::ctl_cmd_t           ctl,
	output ttcn_pkg::dp_stat_t           stat,
	input  logic [ttcn_pkg::IN_W-1:0]    s_tdata,
	input  logic                         cfg_we,
	input  logic [ttcn_pkg::CFG_W-1:0]   cfg_data,
	output logic [ttcn_pkg::OUT_W-1:0]   m_tdata
);
	import ttcn_pkg::*;

	cmd_t                 cmd_q;
	logic [7:0]           gt_q;
	logic [1:0]           k_q;
	vid_t                 lab_q [NLAB];
	vid_t                 x_q;
	logic [CFG_W-1:0]     ts_q;
	logic [SLOT_W-1:0]    cnt_q;
	logic [TBL_W-1:0]     tbl_q;
	vid_t                 list_q [MAX_VARS];
	logic [TBL_W-1:0]     nt_q;
	logic [SLOT_W-1:0]    beat_q;

	logic                 found_c, bad_c;
	logic [SLOT_W-1:0]    i_c;
	logic [MAX_VARS-1:0]  red_c;
	logic [NLAB-1:0]      lt_c [MAX_VARS];
	logic [NLAB-1:0]      eq_c [MAX_VARS];
	logic                 found_s1, bad_s1;
	logic [SLOT_W-1:0]    i_s1;
	logic [MAX_VARS-1:0]  red_s1;
	logic [NLAB-1:0]      lt_s1 [MAX_VARS];
	logic [NLAB-1:0]      eq_s1 [MAX_VARS];

	logic [SLOT_W-1:0]    eff_c;
	logic [MAX_VARS-1:0]  aslot_c, kept_c;
	logic [NLAB-1:0]      fresh_c;
	logic [SLOT_W-1:0]    posl_cmp_c [NLAB];
	logic [SLOT_W-1:0]    posa_c [MAX_VARS];
	logic [SLOT_W-1:0]    rank_c [MAX_VARS];
	logic [SLOT_W-1:0]    nn_c;
	logic [3:0]           nc_c;
	logic [SLOT_W-1:0]    nfresh_c;
	status_t              st_c;
	logic                 upd_c, direct_c;
	logic [3:0]           n_c;
	src_mode_t            mode_c [MAX_VARS];
	logic [SLOT_W-1:0]    src_c [MAX_VARS];
	logic [SLOT_W-1:0]    posl_c [NLAB];
	vid_t                 nl_c [MAX_VARS];

	status_t              st_s2;
	logic                 upd_s2, direct_s2;
	logic [3:0]           n_s2;
	src_mode_t            mode_s2 [MAX_VARS];
	logic [SLOT_W-1:0]    src_s2 [MAX_VARS];
	logic [SLOT_W-1:0]    posl_s2 [NLAB];
	vid_t                 nl_s2 [MAX_VARS];

	logic [LANES-1:0]     lane_bit;
	logic [7:0]           jjx [LANES];
	logic [NLAB-1:0]      gi [LANES];
	logic                 gv [LANES];
	logic [5:0]           tt [LANES];

	logic [SLOT_W-1:0]    last_idx;
	vid_t                 vid_out;

	// command and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= TS_RESET;
			cnt_q <= '0;
			tbl_q <= '0;
		end else begin
			if (cfg_we) begin
				ts_q <= cfg_data;
			end
			if (ctl.commit && upd_s2) begin
				tbl_q <= nt_q & used_mask(n_s2[SLOT_W-1:0]);
				cnt_q <= n_s2[SLOT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd_t'(s_tdata[1:0]);
			gt_q     <= s_tdata[9:2];
			k_q      <= s_tdata[11:10];
			lab_q[0] <= s_tdata[27:12];
			lab_q[1] <= s_tdata[43:28];
			lab_q[2] <= s_tdata[59:44];
			x_q      <= s_tdata[75:60];
		end
		if (ctl.commit && upd_s2) begin
			for (int p = 0; p < MAX_VARS; p++) begin
				if (SLOT_W'(p) < n_s2[SLOT_W-1:0]) begin
					list_q[p] <= nl_s2[p];
				end
			end
		end
		if (ctl.commit) begin
			beat_q <= '0;
		end else if (ctl.beat_adv) begin
			beat_q <= beat_q + 1'b1;
		end
	end

	// prep: match target, compare labels with list, redundancy per variable
	always_comb begin
		logic diff;
		found_c = 1'b0;
		i_c     = '0;
		for (int u = MAX_VARS - 1; u >= 0; u--) begin
			if (SLOT_W'(u) < cnt_q && list_q[u] == x_q) begin
				found_c = 1'b1;
				i_c     = SLOT_W'(u);
			end
		end
		for (int u = 0; u < MAX_VARS; u++) begin
			for (int t = 0; t < NLAB; t++) begin
				lt_c[u][t] = list_q[u] < lab_q[t];
				eq_c[u][t] = list_q[u] == lab_q[t];
			end
		end
		bad_c = (k_q >= 2'd2 && lab_q[1] <= lab_q[0]) ||
			(k_q == 2'd3 && lab_q[2] <= lab_q[1]);
		for (int u = 0; u < MAX_VARS; u++) begin
			diff = 1'b0;
			for (int j = 0; j < TBL_W; j++) begin
				if (((j >> u) & 1) == 0 && 8'(j) < (8'd1 << cnt_q)) begin
					diff = diff | (tbl_q[j] ^ tbl_q[j | (1 << u)]);
				end
			end
			red_c[u] = !diff;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.prep) begin
			found_s1 <= found_c;
			i_s1     <= i_c;
			bad_s1   <= bad_c;
			red_s1   <= red_c;
			lt_s1    <= lt_c;
			eq_s1    <= eq_c;
		end
	end

	// plan: positions in the new list, source of each old index bit, status
	always_comb begin
		logic [SLOT_W-1:0] acc;
		eff_c = (ts_q > CFG_W'(MAX_VARS)) ? SLOT_W'(MAX_VARS) : ts_q;
		for (int u = 0; u < MAX_VARS; u++) begin
			aslot_c[u] = SLOT_W'(u) < cnt_q && !(SLOT_W'(u) == i_s1);
			kept_c[u]  = SLOT_W'(u) < cnt_q && !red_s1[u];
		end
		for (int t = 0; t < NLAB; t++) begin
			fresh_c[t] = (2'(t) < k_q);
			for (int u = 0; u < MAX_VARS; u++) begin
				if (aslot_c[u] && eq_s1[u][t]) begin
					fresh_c[t] = 1'b0;
				end
			end
		end
		nfresh_c = '0;
		for (int t = 0; t < NLAB; t++) begin
			acc = nfresh_c;
			for (int u = 0; u < MAX_VARS; u++) begin
				acc = acc + SLOT_W'(aslot_c[u] && lt_s1[u][t]);
			end
			posl_cmp_c[t] = acc;
			nfresh_c = nfresh_c + SLOT_W'(fresh_c[t]);
		end
		for (int u = 0; u < MAX_VARS; u++) begin
			acc = (SLOT_W'(u) > i_s1) ? SLOT_W'(u - 1) : SLOT_W'(u);
			for (int t = 0; t < NLAB; t++) begin
				acc = acc + SLOT_W'(fresh_c[t] && !lt_s1[u][t] && !eq_s1[u][t]);
			end
			posa_c[u] = acc;
		end
		nn_c = '0;
		for (int u = 0; u < MAX_VARS; u++) begin
			rank_c[u] = nn_c;
			nn_c = nn_c + SLOT_W'(kept_c[u]);
		end
		nc_c = {1'b0, cnt_q} - 4'd1 + {1'b0, nfresh_c};

		st_c     = ST_OK;
		upd_c    = 1'b0;
		direct_c = 1'b0;
		n_c      = {1'b0, cnt_q};
		for (int u = 0; u < MAX_VARS; u++) begin
			mode_c[u] = SRC_ZERO;
			src_c[u]  = '0;
			nl_c[u]   = '0;
		end
		for (int t = 0; t < NLAB; t++) begin
			posl_c[t] = SLOT_W'(t);
		end
		case (cmd_q)
			CMD_IMPORT: begin
				direct_c = 1'b1;
				n_c      = {2'b0, k_q};
				for (int p = 0; p < NLAB; p++) begin
					nl_c[p] = lab_q[p];
				end
				if (bad_s1) begin
					st_c = ST_BAD_LABELS;
				end else if ({1'b0, k_q} > eff_c) begin
					st_c = ST_OVERFLOW;
				end else begin
					upd_c = 1'b1;
				end
			end
			CMD_COMPOSE: begin
				n_c = nc_c;
				for (int t = 0; t < NLAB; t++) begin
					posl_c[t] = (2'(t) < k_q) ? posl_cmp_c[t] : '0;
				end
				for (int u = 0; u < MAX_VARS; u++) begin
					if (SLOT_W'(u) < cnt_q && SLOT_W'(u) == i_s1) begin
						mode_c[u] = SRC_G;
					end else if (aslot_c[u]) begin
						mode_c[u] = SRC_JJ;
						src_c[u]  = posa_c[u];
					end
				end
				for (int p = 0; p < MAX_VARS; p++) begin
					for (int u = 0; u < MAX_VARS; u++) begin
						if (aslot_c[u] && posa_c[u] == SLOT_W'(p)) begin
							nl_c[p] = nl_c[p] | list_q[u];
						end
					end
					for (int t = 0; t < NLAB; t++) begin
						if (fresh_c[t] && posl_cmp_c[t] == SLOT_W'(p)) begin
							nl_c[p] = nl_c[p] | lab_q[t];
						end
					end
				end
				if (bad_s1) begin
					st_c = ST_BAD_LABELS;
				end else if (!found_s1) begin
					st_c = ST_OK;
				end else if (nc_c > {1'b0, eff_c}) begin
					st_c = ST_OVERFLOW;
				end else begin
					upd_c = 1'b1;
				end
			end
			CMD_NORMALIZE: begin
				n_c = {1'b0, nn_c};
				for (int u = 0; u < MAX_VARS; u++) begin
					if (kept_c[u]) begin
						mode_c[u] = SRC_JJ;
						src_c[u]  = rank_c[u];
					end
				end
				for (int p = 0; p < MAX_VARS; p++) begin
					for (int u = 0; u < MAX_VARS; u++) begin
						if (kept_c[u] && rank_c[u] == SLOT_W'(p)) begin
							nl_c[p] = nl_c[p] | list_q[u];
						end
					end
				end
				if (nn_c > eff_c) begin
					st_c = ST_OVERFLOW;
				end else begin
					upd_c = 1'b1;
				end
			end
			default: begin
				st_c = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s2 <= 1'b0;
		end else if (ctl.plan) begin
			upd_s2 <= upd_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.plan) begin
			st_s2     <= st_c;
			direct_s2 <= direct_c;
			n_s2      <= n_c;
			mode_s2   <= mode_c;
			src_s2    <= src_c;
			posl_s2   <= posl_c;
			nl_s2     <= nl_c;
		end
	end

	// eval: rebuild four table bits per cycle
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			jjx[l] = {2'b0, ctl.chunk, LANE_W'(l)};
			for (int t = 0; t < NLAB; t++) begin
				gi[l][t] = jjx[l][posl_s2[t]];
			end
			gv[l] = gval(gt_q, k_q, gi[l]);
			for (int u = 0; u < MAX_VARS; u++) begin
				case (mode_s2[u])
					SRC_JJ:  tt[l][u] = jjx[l][src_s2[u]];
					SRC_G:   tt[l][u] = gv[l];
					default: tt[l][u] = 1'b0;
				endcase
			end
			lane_bit[l] = direct_s2 ? gv[l] : tbl_q[tt[l]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			for (int l = 0; l < LANES; l++) begin
				nt_q[{ctl.chunk, LANE_W'(l)}] <= lane_bit[l];
			end
		end
	end

	// result beats
	assign last_idx       = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
	assign stat.last_beat = (beat_q == last_idx);
	assign vid_out        = (cnt_q != '0) ? list_q[beat_q] : '0;
	assign m_tdata = {7'd0, (cnt_q != '0), vid_out, beat_q, tbl_q, cnt_q, st_s2};

endmodule

FILE: rtl/ttcn_chk.sv
// ttcn_chk: port-level checks of the truth table block, bound to the top.
// Depends on truth_table_compose_normalize_core ports only.
module ttcn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic        m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while results pending");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a beat");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("result run broken before tlast");

	a_empty_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[88] |-> m_tlast && m_tdata[4:2] == 3'd0)
		else $error("empty list must give a single beat");

endmodule

bind truth_table_compose_normalize_core ttcn_chk u_ttcn_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

FILE: bench/ttcn_checker.sv
// ttcn_checker: watches the input, output and config channels of the truth
// table block, predicts each result beat and compares it. Depends on ttcn_pkg.
module ttcn_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [ttcn_pkg::IN_W-1:0]  s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [ttcn_pkg::OUT_W-1:0] m_tdata,
	input  logic                       m_tlast,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [ttcn_pkg::CFG_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         beats_seen
);
	import ttcn_pkg::*;

	typedef struct packed {
		status_t     status;
		logic [2:0]  num_vars;
		logic [63:0] table_res;
		logic [2:0]  var_slot;
		vid_t        var_id;
		logic        var_valid;
		logic        last;
	} result_beat_t;

	vid_t        fn_vars[MAX_VARS];
	int          fn_count;
	logic [63:0] fn_table;
	int          size_reg;
	result_beat_t result_q[$];

	function automatic int cap();
		return size_reg > MAX_VARS ? MAX_VARS : size_reg;
	endfunction

	function automatic int ins_at(int v, int p, int b);
		int lo;
		lo = (1 << p) - 1;
		return (v & lo) | ((b & 1) << p) | ((v & ~lo) << 1);
	endfunction

	function automatic int del_at(int v, int p);
		int lo;
		lo = (1 << p) - 1;
		return (v & lo) | ((v >> 1) & ~lo);
	endfunction

	function automatic int small_val(logic [7:0] gt, int k, int j);
		int idx;
		idx = 0;
		if (k > 0 && j[0]) idx |= 4;
		if (k > 1 && j[1]) idx |= 2;
		if (k > 2 && j[2]) idx |= 1;
		return gt[idx];
	endfunction

	function automatic status_t import_fn(logic [7:0] gt, int k, vid_t lab[3]);
		logic [63:0] t;
		t = '0;
		if (k > cap()) return ST_OVERFLOW;
		for (int j = 0; j < (1 << k); j++) t[j] = small_val(gt, k, j);
		for (int j = 0; j < k; j++) fn_vars[j] = lab[j];
		fn_count = k;
		fn_table = t;
		return ST_OK;
	endfunction

	function automatic status_t compose_fn(logic [7:0] gt, int k, vid_t lab[3], vid_t x);
		vid_t a[MAX_VARS];
		vid_t c[MAX_VARS+3];
		int pos[3];
		int fresh[3];
		int i, na, ia, n, tt, gi;
		logic [63:0] nt;
		nt = '0;
		i = 0;
		while (i < fn_count && fn_vars[i] != x) i++;
		if (i >= fn_count) return ST_OK;
		na = 0;
		for (int t = 0; t < fn_count; t++) if (t != i) a[na++] = fn_vars[t];
		ia = 0;
		n = 0;
		for (int t = 0; t < k; t++) begin
			while (ia < na && a[ia] < lab[t]) c[n++] = a[ia++];
			pos[t] = n;
			if (ia == na || a[ia] != lab[t]) begin
				fresh[t] = 1;
				c[n++] = lab[t];
			end else begin
				fresh[t] = 0;
			end
		end
		while (ia < na) c[n++] = a[ia++];
		if (n > cap()) return ST_OVERFLOW;
		for (int jj = 0; jj < (1 << n); jj++) begin
			gi = 0;
			for (int t = 0; t < k; t++) gi |= ((jj >> pos[t]) & 1) << t;
			tt = jj;
			for (int t = k; t > 0; t--) if (fresh[t-1]) tt = del_at(tt, pos[t-1]);
			tt = ins_at(tt, i, small_val(gt, k, gi));
			nt[jj] = fn_table[tt & 63];
		end
		for (int t = 0; t < n; t++) fn_vars[t] = c[t];
		fn_count = n;
		fn_table = nt;
		return ST_OK;
	endfunction

	function automatic status_t normalize_fn();
		vid_t keep[MAX_VARS];
		int dropped[MAX_VARS];
		int n, nr, t;
		logic red;
		logic [63:0] nt;
		n = 0;
		nr = 0;
		nt = '0;
		for (int i = 0; i < fn_count; i++) begin
			red = 1'b1;
			for (int j = 0; j < (1 << (fn_count - 1)); j++)
				if (fn_table[ins_at(j, i, 0)] != fn_table[ins_at(j, i, 1)]) red = 1'b0;
			if (red) dropped[nr++] = i;
			else keep[n++] = fn_vars[i];
		end
		if (n > cap()) return ST_OVERFLOW;
		for (int j = 0; j < (1 << n); j++) begin
			t = j;
			for (int r = 0; r < nr; r++) t = ins_at(t, dropped[r], 0);
			nt[j] = fn_table[t];
		end
		for (int i = 0; i < n; i++) fn_vars[i] = keep[i];
		fn_count = n;
		fn_table = nt;
		return ST_OK;
	endfunction

	function automatic void predict_item(logic [IN_W-1:0] d);
		cmd_t        op;
		int          k, nres;
		vid_t        lab[3];
		status_t     st;
		result_beat_t rb;
		op = cmd_t'(d[1:0]);
		k = d[11:10];
		lab[0] = d[27:12];
		lab[1] = d[43:28];
		lab[2] = d[59:44];
		st = ST_OK;
		if (op == CMD_IMPORT || op == CMD_COMPOSE) begin
			for (int t = 1; t < k; t++) if (lab[t] <= lab[t-1]) st = ST_BAD_LABELS;
			if (st == ST_OK)
				st = (op == CMD_IMPORT) ? import_fn(d[9:2], k, lab)
					: compose_fn(d[9:2], k, lab, d[75:60]);
		end else if (op == CMD_NORMALIZE) begin
			st = normalize_fn();
		end
		if (fn_count < 6) fn_table &= (64'd1 << (1 << fn_count)) - 64'd1;
		nres = fn_count > 0 ? fn_count : 1;
		for (int t = 0; t < nres; t++) begin
			rb.status    = st;
			rb.num_vars  = 3'(fn_count);
			rb.table_res = fn_table;
			rb.var_slot  = 3'(t);
			rb.var_id    = fn_count > 0 ? fn_vars[t] : '0;
			rb.var_valid = fn_count > 0;
			rb.last      = (t + 1 == nres);
			result_q.push_back(rb);
		end
	endfunction

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_beat_t e;
		if (!arst_n) begin
			fn_count = 0;
			fn_table = '0;
			size_reg = TS_RESET;
			result_q.delete();
			fail_count = 0;
			beats_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) size_reg = cfg_data;
			if (s_tvalid && s_tready) predict_item(s_tdata);
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (result_q.size() == 0) begin
					$error("output beat with no expected result");
					fail_count++;
				end else begin
					e = result_q.pop_front();
					compare_field("status", e.status, m_tdata[1:0]);
					compare_field("num_vars", e.num_vars, m_tdata[4:2]);
					compare_field("table_res", e.table_res, m_tdata[68:5]);
					compare_field("var_slot", e.var_slot, m_tdata[71:69]);
					compare_field("var_id", e.var_id, m_tdata[87:72]);
					compare_field("var_valid", e.var_valid, m_tdata[88]);
					compare_field("last", e.last, m_tlast);
				end
			end
		end
		pending = result_q.size();
	end
endmodule

FILE: bench/tb_truth_table_compose_normalize_core.sv
// tb_truth_table_compose_normalize_core: drives commands and table_size writes
// into the truth table block; ttcn_checker judges. Depends on ttcn_pkg.
module tb_truth_table_compose_normalize_core;
	import ttcn_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [OUT_W-1:0]   m_tdata;
	logic               m_tlast;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data;
	int                 fail_count, pending, beats_seen;
	int                 cycle_count;
	int                 items_sent;
	logic               quiet;
	logic               hold_long;

	vid_t pool[8] = '{16'h0000, 16'h0003, 16'h0010, 16'h0011, 16'h0100,
		16'h7FFF, 16'hAAAA, 16'hFFFF};

	truth_table_compose_normalize_core DUT (.*);

	ttcn_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("tb_truth_table_compose_normalize_core: done, errors");
				$finish;
			end
		end
	end

	// sink: random stall bursts, one long hold while the source keeps offering
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_long = 1'b0;
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 9);
				m_tready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [IN_W-1:0] pack_item(cmd_t op, logic [7:0] gt, logic [1:0] k,
			vid_t v0, vid_t v1, vid_t v2, vid_t x);
		return {4'b0, x, v2, v1, v0, k, gt, op};
	endfunction

	task automatic send_item(logic [IN_W-1:0] d);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain_and_config(logic [CFG_W-1:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic vid_t rand_id(logic wide);
		return wide ? vid_t'($urandom) : pool[$urandom_range(0, 7)];
	endfunction

	task automatic random_item(logic wide);
		vid_t v[3];
		vid_t t;
		int r;
		cmd_t op;
		logic [1:0] k;
		for (int i = 0; i < 3; i++) v[i] = rand_id(wide);
		if ($urandom_range(0, 9) != 0) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 2 - i; j++)
					if (v[j] > v[j+1]) begin
						t = v[j];
						v[j] = v[j+1];
						v[j+1] = t;
					end
			if (v[1] == v[0]) v[1] = v[0] + 1;
			if (v[2] <= v[1]) v[2] = v[1] + 1;
		end
		r = $urandom_range(0, 19);
		op = r < 5 ? CMD_IMPORT : r < 15 ? CMD_COMPOSE : r < 19 ? CMD_NORMALIZE : CMD_NOP;
		k = $urandom_range(0, 3);
		t = $urandom_range(0, 3) == 0 ? rand_id(wide) : pool[$urandom_range(0, 7)];
		send_item(pack_item(op, 8'($urandom), k, v[0], v[1], v[2], t));
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_long = 1'b0;
		items_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_item(pack_item(CMD_NORMALIZE, 8'h00, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(pack_item(CMD_IMPORT, 8'hFF, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(pack_item(CMD_IMPORT, 8'h96, 2'd3, 16'h0, 16'h10, 16'hFFFF, 16'h0));
		send_item(pack_item(CMD_COMPOSE, 8'hE8, 2'd3, 16'h1, 16'h2, 16'h3, 16'h10));
		send_item(pack_item(CMD_COMPOSE, 8'h6A, 2'd3, 16'h4, 16'h5, 16'h6, 16'h2));
		send_item(pack_item(CMD_COMPOSE, 8'h5A, 2'd2, 16'h2, 16'h7FFF, 16'h0, 16'h1234));
		send_item(pack_item(CMD_COMPOSE, 8'h0F, 2'd1, 16'h3, 16'h0, 16'h0, 16'h3));
		send_item(pack_item(CMD_NORMALIZE, 8'h00, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		send_item(pack_item(CMD_IMPORT, 8'h55, 2'd3, 16'h5, 16'h5, 16'h6, 16'h0));
		send_item(pack_item(CMD_COMPOSE, 8'hAA, 2'd2, 16'h9, 16'h8, 16'h0, 16'h0));
		send_item(pack_item(CMD_NOP, 8'hFF, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_item(pack_item(CMD_IMPORT, 8'hC3, 2'd2, 16'h8000, 16'hFFFF, 16'h0, 16'h0));
		send_item(pack_item(CMD_COMPOSE, 8'h00, 2'd0, 16'h0, 16'h0, 16'h0, 16'h8000));
		send_item(pack_item(CMD_NORMALIZE, 8'h00, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		drain_and_config(3'd3);
		send_item(pack_item(CMD_IMPORT, 8'h96, 2'd3, 16'h1, 16'h2, 16'h3, 16'h0));
		send_item(pack_item(CMD_COMPOSE, 8'h96, 2'd3, 16'h4, 16'h5, 16'h6, 16'h1));
		send_item(pack_item(CMD_COMPOSE, 8'h0F, 2'd1, 16'h7, 16'h0, 16'h0, 16'h1));
		drain_and_config(3'd6);
		send_item(pack_item(CMD_COMPOSE, 8'h96, 2'd3, 16'h4, 16'h5, 16'h6, 16'h2));
		send_item(pack_item(CMD_COMPOSE, 8'h96, 2'd3, 16'h8, 16'h9, 16'hA, 16'h4));
		drain_and_config(3'd3);
		send_item(pack_item(CMD_NORMALIZE, 8'h00, 2'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		drain_and_config(3'd7);

		// long receiver hold while items keep coming
		hold_long = 1'b1;
		for (int i = 0; i < 8; i++) random_item(1'b0);

		for (int i = 0; i < 152; i++) begin
			if (i == 50) drain_and_config(3'd4);
			if (i == 90) drain_and_config(3'd5);
			if (i == 120) drain_and_config(3'd6);
			if (i == 130) quiet = 1'b1;
			random_item($urandom_range(0, 4) == 0);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("covered %0d commands, %0d result beats, table_size 3..7 incl. overflow",
			items_sent, beats_seen);
		if (fail_count == 0) begin
			$display("tb_truth_table_compose_normalize_core: done, clean");
		end else begin
			$display("tb_truth_table_compose_normalize_core: done, errors");
		end
		$finish;
	end
endmodule
